// ===== rtl/core/rgbhsv_pkg.sv =====
// shared types and constants for the rgb to hsv converter
`default_nettype none
package rgbhsv_pkg;
    localparam int unsigned CH_W     = 8;
    localparam int unsigned HUE_W    = 15;
    localparam int unsigned PCT_W    = 13;
    localparam int unsigned QDEPTH   = 4;
    localparam int unsigned QUO_W    = 16;
    localparam int unsigned NUM_W    = 24;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2,
        SEC_GREY  = 2'd3
    } sector_t;

    // classified pixel passed from front to back
    typedef struct packed {
        logic [CH_W-1:0]  mx;
        logic [CH_W-1:0]  d;
        logic [CH_W-1:0]  p;
        logic [CH_W-1:0]  q;
        sector_t          sector;
    } cls_t;

    // result item
    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] val;
    } res_t;
endpackage
`default_nettype wire

// ===== rtl/core/rgbhsv_front.sv =====
// front stage: max, min and sector classification
`default_nettype none
module rgbhsv_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [rgbhsv_pkg::CH_W-1:0] red,
    input  wire logic [rgbhsv_pkg::CH_W-1:0] green,
    input  wire logic [rgbhsv_pkg::CH_W-1:0] blue,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    output rgbhsv_pkg::cls_t                 cls,
    output logic                             cls_valid,
    input  wire logic                        cls_ready
);
    rgbhsv_pkg::cls_t cls_reg, cls_next;
    logic             vld_reg;
    logic [rgbhsv_pkg::CH_W-1:0] mx, mn;

    assign in_ready  = !vld_reg || cls_ready;
    assign cls       = cls_reg;
    assign cls_valid = vld_reg;

    always_comb
    begin
        mx = red;
        mn = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;
        cls_next.mx = mx;
        cls_next.d  = mx - mn;
        if (mx == mn)
        begin
            cls_next.sector = rgbhsv_pkg::SEC_GREY;
            cls_next.p = green;
            cls_next.q = blue;
        end
        else if (mx == red)
        begin
            cls_next.sector = rgbhsv_pkg::SEC_RED;
            cls_next.p = green;
            cls_next.q = blue;
        end
        else if (mx == green)
        begin
            cls_next.sector = rgbhsv_pkg::SEC_GREEN;
            cls_next.p = blue;
            cls_next.q = red;
        end
        else
        begin
            cls_next.sector = rgbhsv_pkg::SEC_BLUE;
            cls_next.p = red;
            cls_next.q = green;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            cls_reg <= cls_next;
    end
endmodule
`default_nettype wire

// ===== rtl/core/rgbhsv_queue.sv =====
// small fifo between front and back
`default_nettype none
module rgbhsv_queue #(
    parameter int unsigned DEPTH = rgbhsv_pkg::QDEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  rgbhsv_pkg::cls_t wr_data,
    input  wire logic       wr_valid,
    output logic            wr_ready,
    output rgbhsv_pkg::cls_t rd_data,
    output logic            rd_valid,
    input  wire logic       rd_ready
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    rgbhsv_pkg::cls_t mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          wr_en, rd_en;

    assign wr_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;
    assign rd_data  = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_data;
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH)) else $error("queue count overflow");
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wp_reg == rp_reg)) else $error("pointer mismatch");
    a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == (AW+1)'(DEPTH)) |-> (wp_reg == rp_reg))
        else $error("pointer mismatch when full");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/rgbhsv_back.sv =====
// back pipeline: pipelined dividers for hue and saturation, value by reciprocal
`default_nettype none
module rgbhsv_back (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  rgbhsv_pkg::cls_t cls,
    input  wire logic        cls_valid,
    output logic             cls_ready,
    output rgbhsv_pkg::res_t res,
    output logic             res_valid,
    input  wire logic        res_ready
);
    localparam int unsigned NW = rgbhsv_pkg::NUM_W;
    localparam int unsigned QW = rgbhsv_pkg::QUO_W;
    localparam int unsigned CW = rgbhsv_pkg::CH_W;
    // restoring division, two quotient bits per stage
    localparam int unsigned BPS    = 2;
    localparam int unsigned NSTAGE = QW / BPS;
    localparam int unsigned LAST   = NSTAGE + 1;

    typedef struct packed {
        logic [NW-1:0] hnum;
        logic [NW-1:0] snum;
        logic [CW-1:0] d;
        logic [CW-1:0] mx;
        logic [CW:0]   hrem;
        logic [CW:0]   srem;
        logic [QW-1:0] hq;
        logic [QW-1:0] sq;
        logic [rgbhsv_pkg::PCT_W-1:0] val;
        logic          grey;
        logic          black;
    } stg_t;

    stg_t          st_reg [LAST];
    logic [LAST-1:0] v_reg;
    rgbhsv_pkg::res_t res_reg;
    logic          rv_reg;
    logic          adv;
    stg_t          s0_next;
    stg_t          st_next [LAST];
    logic [NW-1:0] base;
    logic [NW-1:0] hnum_full, snum_full;
    logic [13:0]   pl, ql;
    logic [21:0]   mxl;
    logic [QW:0]   hue_w;

    assign adv       = !rv_reg || res_ready;
    assign cls_ready = adv;
    assign res       = res_reg;
    assign res_valid = rv_reg;

    // stage 0: numerators, value via multiply by reciprocal
    // numerators are below 2^16 times divisor: skip leading 8 bits
    // (stage 0 pre-shifts by putting top byte into the remainder)
    always_comb
    begin
        unique case (cls.sector)
            rgbhsv_pkg::SEC_GREEN: base = NW'(7680);
            rgbhsv_pkg::SEC_BLUE:  base = NW'(15360);
            default:               base = NW'(23040);
        endcase
        pl = {cls.p, 6'd0} - 14'({cls.p, 2'd0});
        ql = {cls.q, 6'd0} - 14'({cls.q, 2'd0});
        hnum_full     = base * NW'(cls.d) + NW'({pl, 6'd0}) - NW'({ql, 6'd0});
        snum_full     = NW'(cls.d) * NW'(6400);
        s0_next       = '0;
        s0_next.hrem  = {1'b0, hnum_full[NW-1 -: CW]};
        s0_next.srem  = {1'b0, snum_full[NW-1 -: CW]};
        s0_next.hnum  = {hnum_full[NW-CW-1:0], CW'(0)};
        s0_next.snum  = {snum_full[NW-CW-1:0], CW'(0)};
        s0_next.d     = cls.d;
        s0_next.mx    = cls.mx;
        // mx*6400/255 = floor(mx*6400*257/65535); exact for mx<=255
        mxl           = 22'(cls.mx) * 22'(6400);
        s0_next.val   = rgbhsv_pkg::PCT_W'((mxl + 22'(mxl >> 8) + 22'(mxl >> 16)
                        + 22'd1) >> 8 >> 0) ;
        s0_next.grey  = (cls.sector == rgbhsv_pkg::SEC_GREY);
        s0_next.black = (cls.mx == '0);
    end

    always_comb
    begin
        logic [CW+1:0] hr, sr;
        logic [CW+1:0] ht, stt;
        st_next[0] = s0_next;
        for (int s = 1; s < LAST; s++)
        begin
            st_next[s] = st_reg[s-1];
            hr = {1'b0, st_reg[s-1].hrem};
            sr = {1'b0, st_reg[s-1].srem};
            for (int b = 0; b < BPS; b++)
            begin
                hr = {hr[CW:0], st_next[s].hnum[NW-1]};
                st_next[s].hnum = {st_next[s].hnum[NW-2:0], 1'b0};
                ht = hr - {2'b0, st_reg[s-1].d};
                if (!ht[CW+1])
                    hr = ht;
                st_next[s].hq = {st_next[s].hq[QW-2:0], !ht[CW+1]};
                sr = {sr[CW:0], st_next[s].snum[NW-1]};
                st_next[s].snum = {st_next[s].snum[NW-2:0], 1'b0};
                stt = sr - {2'b0, st_reg[s-1].mx};
                if (!stt[CW+1])
                    sr = stt;
                st_next[s].sq = {st_next[s].sq[QW-2:0], !stt[CW+1]};
            end
            st_next[s].hrem = hr[CW:0];
            st_next[s].srem = sr[CW:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            rv_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg  <= {v_reg[LAST-2:0], cls_valid};
            rv_reg <= v_reg[LAST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= s0_next;
            for (int s = 1; s < LAST; s++)
                st_reg[s] <= st_next[s];
            res_reg.hue <= st_reg[LAST-1].grey ? '0 :
                           rgbhsv_pkg::HUE_W'((hue_w >= (QW+1)'(23040)) ?
                           hue_w - (QW+1)'(23040) : hue_w);
            res_reg.sat <= st_reg[LAST-1].black ? '0 :
                           rgbhsv_pkg::PCT_W'(st_reg[LAST-1].sq);
            res_reg.val <= st_reg[LAST-1].val;
        end
    end

    assign hue_w = {1'b0, st_reg[LAST-1].hq};

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("result changed while stalled");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.hue < rgbhsv_pkg::HUE_W'(23040) &&
        res.sat <= rgbhsv_pkg::PCT_W'(6400) && res.val <= rgbhsv_pkg::PCT_W'(6400)))
        else $error("result out of range");
    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v_reg[LAST-1] && st_reg[LAST-1].grey) |=> (res.hue == '0))
        else $error("grey pixel with nonzero hue");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/rgb_to_hsv_converter.sv =====
// top level of the rgb to hsv pixel converter
`default_nettype none
// Converts one 8-bit rgb pixel per item into hue (1/64 degree, 0..23039),
// saturation and brightness (1/64 percent, 0..6400), each floored. A front
// stage finds max, min and the hue sector and registers max, max-min and
// the sector; a four-entry queue decouples it from the back pipeline, which
// runs two restoring divisions (hue and saturation) at two quotient bits per
// stage. One item is accepted every cycle while the output is not stalled;
// a result passes the front register, the queue, nine back stages and the
// output register. Grey pixels give hue 0 and black pixels saturation 0.
module rgb_to_hsv_converter #(
    parameter int unsigned QUEUE_DEPTH = rgbhsv_pkg::QDEPTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [rgbhsv_pkg::CH_W-1:0]  red,
    input  wire logic [rgbhsv_pkg::CH_W-1:0]  green,
    input  wire logic [rgbhsv_pkg::CH_W-1:0]  blue,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [rgbhsv_pkg::HUE_W-1:0]      hue,
    output logic [rgbhsv_pkg::PCT_W-1:0]      saturation,
    output logic [rgbhsv_pkg::PCT_W-1:0]      brightness
);
    rgbhsv_pkg::cls_t f_cls, q_cls;
    logic             f_valid, f_ready, q_valid, q_ready;
    rgbhsv_pkg::res_t res;

    // front: classify
    rgbhsv_front u_front (
        .clk, .rst_n, .red, .green, .blue,
        .in_valid, .in_ready,
        .cls(f_cls), .cls_valid(f_valid), .cls_ready(f_ready)
    );

    // decoupling queue
    rgbhsv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk, .rst_n,
        .wr_data(f_cls), .wr_valid(f_valid), .wr_ready(f_ready),
        .rd_data(q_cls), .rd_valid(q_valid), .rd_ready(q_ready)
    );

    // back: dividers
    rgbhsv_back u_back (
        .clk, .rst_n,
        .cls(q_cls), .cls_valid(q_valid), .cls_ready(q_ready),
        .res, .res_valid(out_valid), .res_ready(out_ready)
    );

    assign hue        = res.hue;
    assign saturation = res.sat;
    assign brightness = res.val;
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for the rgb to hsv pixel converter
`timescale 1ns / 100ps

// holds predicted hsv results in arrival order and checks the block's output
class hsv_scoreboard;
    typedef struct packed {
        logic [rgbhsv_pkg::HUE_W-1:0] hue;
        logic [rgbhsv_pkg::PCT_W-1:0] sat;
        logic [rgbhsv_pkg::PCT_W-1:0] val;
    } hsv_t;

    hsv_t pending_hsv[$];
    int   mismatches;
    int   results_seen;
    int   pixels_seen;

    function new();
        mismatches = 0;
        results_seen = 0;
        pixels_seen = 0;
    endfunction

    // fixed-point hsv of one pixel, floored, ties go red then green then blue
    function hsv_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned mx;
        int unsigned mn;
        int unsigned d;
        int unsigned p;
        int unsigned q;
        int unsigned base;
        int unsigned num;
        hsv_t res;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        res.val = 13'((mx * 6400) / 255);
        res.sat = (mx != 0) ? 13'((d * 6400) / mx) : 13'd0;
        res.hue = '0;
        if (d != 0)
        begin
            if (mx == r)
            begin
                p = g; q = b; base = 23040;
            end
            else if (mx == g)
            begin
                p = b; q = r; base = 7680;
            end
            else
            begin
                p = r; q = g; base = 15360;
            end
            num = base * d + 3840 * p - 3840 * q;
            res.hue = 15'((num / d) % 23040);
        end
        return res;
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pending_hsv.push_back(convert_pixel(r, g, b));
        pixels_seen++;
    endfunction

    function void check_result(logic [14:0] hue, logic [12:0] sat, logic [12:0] val);
        hsv_t exp_hsv;
        results_seen++;
        if (pending_hsv.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result hue=%0d sat=%0d val=%0d", hue, sat, val);
            return;
        end
        exp_hsv = pending_hsv.pop_front();
        if (exp_hsv.hue !== hue || exp_hsv.sat !== sat || exp_hsv.val !== val)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected hue=%0d sat=%0d val=%0d, got hue=%0d sat=%0d val=%0d",
                         exp_hsv.hue, exp_hsv.sat, exp_hsv.val, hue, sat, val);
        end
    endfunction
endclass

module tb_top;
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        out_valid;
    logic        out_ready;
    logic [14:0] hue;
    logic [12:0] saturation;
    logic [12:0] brightness;

    // percent of cycles in which each side holds back
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    hsv_scoreboard hsv_sb;

    rgb_to_hsv_converter u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #2000000;
        $display("timeout waiting for the converter");
        $display("CHECKS FAILED");
        $finish;
    end

    // sink side: random stalls on out_ready, check every accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                hsv_sb.check_result(hue, saturation, brightness);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // present one pixel, hold it until accepted; random idle cycles go first
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        do
            @(posedge clk);
        while (!in_ready);
        hsv_sb.note_pixel(r, g, b);
        // valid stays up; the next call or drain decides whether it drops
    endtask

    // random pixel biased toward ties, greys and near-greys
    task automatic send_random_pixel();
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        int unsigned kind;
        r = $urandom;
        g = $urandom;
        b = $urandom;
        kind = $urandom_range(9);
        case (kind)
            0:
            begin
                g = r;
                b = r;
            end
            1: g = r;
            2: b = g;
            3: b = r;
            4:
            begin
                g = r + 8'($urandom_range(2));
                b = r - 8'($urandom_range(2));
            end
            default: ;
        endcase
        send_pixel(r, g, b);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (hsv_sb.pending_hsv.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        hsv_sb = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        out_ready = 1'b0;
        red       = '0;
        green     = '0;
        blue      = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: black, white, greys, pure and mixed hues, ties on the max
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd255, 8'd254, 8'd0);
        send_pixel(8'd200, 8'd200, 8'd10);
        send_pixel(8'd10,  8'd200, 8'd200);
        send_pixel(8'd200, 8'd10,  8'd200);
        send_pixel(8'd170, 8'd85,  8'd255);
        send_pixel(8'd255, 8'd1,   8'd254);
        send_pixel(8'd254, 8'd255, 8'd253);
        send_pixel(8'd85,  8'd170, 8'd0);
        drain();

        // three idle profiles over the random pixels
        send_idle_pct = 24;
        recv_idle_pct = 48;
        repeat (230) send_random_pixel();
        send_idle_pct = 48;
        recv_idle_pct = 24;
        repeat (230) send_random_pixel();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (240) send_random_pixel();

        drain();
        repeat (30) @(posedge clk);

        $display("converted %0d pixels, %0d results checked: greys, blacks, max ties, random",
                 hsv_sb.pixels_seen, hsv_sb.results_seen);
        $display("stall mixes covered: sender-heavy, receiver-heavy and none");
        if (hsv_sb.mismatches == 0 && hsv_sb.pending_hsv.size() == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0d mismatches", hsv_sb.mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
